FILE: hdl/coag_pkg.sv
// coag_pkg: shared types and codes for the cpu operand address generator
// holds addressing mode codes, transaction kinds, phase enum and payload structs
// no dependencies
package coag_pkg;

	localparam int unsigned ModeWidth = 4;
	localparam int unsigned AddrWidth = 16;
	localparam int unsigned ByteWidth = 8;

	localparam logic [ModeWidth-1:0] MODE_ACC = 4'd0;
	localparam logic [ModeWidth-1:0] MODE_IMM = 4'd1;
	localparam logic [ModeWidth-1:0] MODE_ABS = 4'd2;
	localparam logic [ModeWidth-1:0] MODE_ABX = 4'd3;
	localparam logic [ModeWidth-1:0] MODE_ABY = 4'd4;
	localparam logic [ModeWidth-1:0] MODE_ZP  = 4'd5;
	localparam logic [ModeWidth-1:0] MODE_ZPX = 4'd6;
	localparam logic [ModeWidth-1:0] MODE_ZPY = 4'd7;
	localparam logic [ModeWidth-1:0] MODE_IND = 4'd8;
	localparam logic [ModeWidth-1:0] MODE_INX = 4'd9;
	localparam logic [ModeWidth-1:0] MODE_INY = 4'd10;
	localparam logic [ModeWidth-1:0] MODE_REL = 4'd11;

	localparam logic KIND_START = 1'b0;
	localparam logic KIND_DATA  = 1'b1;

	localparam logic [1:0] OUT_READ_REQ   = 2'd0;
	localparam logic [1:0] OUT_ADDR_READY = 2'd1;
	localparam logic [1:0] OUT_UNEXPECTED = 2'd2;

	typedef enum logic [2:0] {
		PH_IDLE   = 3'd0,
		PH_OP_LO  = 3'd1,
		PH_OP_HI  = 3'd2,
		PH_PTR_LO = 3'd3,
		PH_PTR_HI = 3'd4
	} phase_t;

	typedef struct packed {
		logic                 kind;
		logic [ModeWidth-1:0] mode;
		logic [AddrWidth-1:0] pc_in;
		logic [ByteWidth-1:0] x_index;
		logic [ByteWidth-1:0] y_index;
		logic [ByteWidth-1:0] read_data;
	} in_item_t;

	typedef struct packed {
		logic [1:0]           out_kind;
		logic [AddrWidth-1:0] address;
		logic [AddrWidth-1:0] pc_out;
	} out_item_t;

endpackage

FILE: hdl/cpu_operand_address_generator_top.sv
// cpu_operand_address_generator_top: operand address sequencer for 6502 style modes
// input register, one pass of address logic, result register
// depends on coag_pkg
//
//  channel | direction | payload    | handshake
//  item    | in        | in_item_t  | item_valid / item_stall
//  result  | out       | out_item_t | result_valid / result_stall
//
// every item gives one result, registered in the input register and then in the result register
// one item accepted per cycle while item_stall is low; job state updates as an item leaves the input register
// arst_n clears the phase, job registers and both valid flags
// result_stall backs up into the input register and then raises item_stall
module cpu_operand_address_generator_top
	import coag_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      item_valid,
	output logic      item_stall,
	input  in_item_t  item,
	output logic      result_valid,
	input  logic      result_stall,
	output out_item_t result
);

	logic     valid_s1;
	in_item_t item_s1;

	phase_t                phase_q, phase_d;
	logic [ModeWidth-1:0]  mode_q, mode_d;
	logic [ByteWidth-1:0]  index_q, index_d;
	logic [AddrWidth-1:0]  pc_q, pc_d;
	logic [ByteWidth-1:0]  low_q, low_d;
	logic [AddrWidth-1:0]  ptr_q, ptr_d;
	out_item_t             res_d;

	logic advance;
	logic fire;
	logic [AddrWidth-1:0] word;
	logic [AddrWidth-1:0] pc_next;

	assign advance    = !result_valid || !result_stall;
	assign fire       = valid_s1 && advance;
	assign item_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= item;
		end
	end

	assign word = {item_s1.read_data, low_q};

	always_comb begin
		phase_d = phase_q;
		mode_d  = mode_q;
		index_d = index_q;
		pc_d    = pc_q;
		low_d   = low_q;
		ptr_d   = ptr_q;
		pc_next = pc_q + 16'd1;
		res_d   = '{out_kind: OUT_ADDR_READY, address: '0, pc_out: pc_q};

		if (item_s1.kind == KIND_START) begin
			mode_d = item_s1.mode;
			if (item_s1.mode == MODE_ABY || item_s1.mode == MODE_ZPY ||
			    item_s1.mode == MODE_INY) begin
				index_d = item_s1.y_index;
			end else begin
				index_d = item_s1.x_index;
			end
			low_d   = '0;
			ptr_d   = '0;
			pc_next = item_s1.pc_in + 16'd1;
			if (item_s1.mode == MODE_ACC || item_s1.mode > MODE_REL) begin
				phase_d = PH_IDLE;
				pc_d    = item_s1.pc_in;
				res_d   = '{out_kind: OUT_ADDR_READY, address: '0, pc_out: item_s1.pc_in};
			end else if (item_s1.mode == MODE_IMM) begin
				phase_d = PH_IDLE;
				pc_d    = pc_next;
				res_d   = '{out_kind: OUT_ADDR_READY, address: item_s1.pc_in,
				            pc_out: pc_next};
			end else begin
				phase_d = PH_OP_LO;
				pc_d    = pc_next;
				res_d   = '{out_kind: OUT_READ_REQ, address: item_s1.pc_in,
				            pc_out: pc_next};
			end
		end else begin
			case (phase_q)
				PH_OP_LO: begin
					if (mode_q == MODE_ZP || mode_q == MODE_REL) begin
						phase_d = PH_IDLE;
						res_d   = '{out_kind: OUT_ADDR_READY,
						            address: {8'h00, item_s1.read_data}, pc_out: pc_q};
					end else if (mode_q == MODE_ZPX || mode_q == MODE_ZPY) begin
						phase_d = PH_IDLE;
						res_d   = '{out_kind: OUT_ADDR_READY,
						            address: {8'h00, item_s1.read_data + index_q},
						            pc_out: pc_q};
					end else if (mode_q == MODE_INX) begin
						phase_d = PH_PTR_LO;
						ptr_d   = {8'h00, item_s1.read_data + index_q};
						res_d   = '{out_kind: OUT_READ_REQ, address: ptr_d, pc_out: pc_q};
					end else if (mode_q == MODE_INY) begin
						phase_d = PH_PTR_LO;
						ptr_d   = {8'h00, item_s1.read_data};
						res_d   = '{out_kind: OUT_READ_REQ, address: ptr_d, pc_out: pc_q};
					end else begin
						// absolute forms and ind fetch the high operand byte
						phase_d = PH_OP_HI;
						low_d   = item_s1.read_data;
						pc_d    = pc_next;
						res_d   = '{out_kind: OUT_READ_REQ, address: pc_q, pc_out: pc_next};
					end
				end
				PH_OP_HI: begin
					if (mode_q == MODE_IND) begin
						phase_d = PH_PTR_LO;
						ptr_d   = word;
						res_d   = '{out_kind: OUT_READ_REQ, address: word, pc_out: pc_q};
					end else if (mode_q == MODE_ABX || mode_q == MODE_ABY) begin
						phase_d = PH_IDLE;
						res_d   = '{out_kind: OUT_ADDR_READY,
						            address: word + {8'h00, index_q}, pc_out: pc_q};
					end else begin
						phase_d = PH_IDLE;
						res_d   = '{out_kind: OUT_ADDR_READY, address: word, pc_out: pc_q};
					end
				end
				PH_PTR_LO: begin
					// high pointer byte: no page wrap
					phase_d = PH_PTR_HI;
					low_d   = item_s1.read_data;
					res_d   = '{out_kind: OUT_READ_REQ, address: ptr_q + 16'd1, pc_out: pc_q};
				end
				PH_PTR_HI: begin
					phase_d = PH_IDLE;
					if (mode_q == MODE_INY) begin
						res_d = '{out_kind: OUT_ADDR_READY,
						          address: word + {8'h00, index_q}, pc_out: pc_q};
					end else begin
						res_d = '{out_kind: OUT_ADDR_READY, address: word, pc_out: pc_q};
					end
				end
				default: begin
					phase_d = PH_IDLE;
					res_d   = '{out_kind: OUT_UNEXPECTED, address: '0, pc_out: '0};
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			mode_q  <= '0;
			index_q <= '0;
			pc_q    <= '0;
			low_q   <= '0;
			ptr_q   <= '0;
		end else if (fire) begin
			phase_q <= phase_d;
			mode_q  <= mode_d;
			index_q <= index_d;
			pc_q    <= pc_d;
			low_q   <= low_d;
			ptr_q   <= ptr_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (advance) begin
			result_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			result <= res_d;
		end
	end

endmodule
